>>> rtl/sidx_pkg.sv
package sidx_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HDR_IDS   = 2'd0;
  localparam logic [1:0] KIND_HDR_TIMES = 2'd1;
  localparam logic [1:0] KIND_ENTRY     = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_LARGE_SIZE    = 2'd1;
  localparam logic [1:0] STATUS_SIZE_MISMATCH = 2'd2;

  // Result queue depth (at least 2: one byte can raise two results)
  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       box_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [1:0]  status;
    logic [63:0] value_a;
    logic [63:0] value_b;
    logic [15:0] reference_count;
    logic        reference_type;
    logic        starts_with_sap;
    logic [2:0]  sap_type;
    logic [27:0] sap_delta_time;
  } out_item_t;

endpackage

>>> rtl/sidx_res_fifo.sv
module sidx_res_fifo #(
  parameter int unsigned DEPTH = sidx_pkg::RES_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_a,
  input  sidx_pkg::out_item_t data_a,
  input  logic                push_b,
  input  sidx_pkg::out_item_t data_b,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_stall,
  output sidx_pkg::out_item_t out_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sidx_pkg::out_item_t q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wr_ptr_p1;
  logic          pop;

  function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
    inc_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign room2     = (cnt_r <= CW'(DEPTH - 2));
  assign wr_ptr_p1 = inc_ptr(wr_ptr_r);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_a && push_b) begin
      wr_ptr_nxt = inc_ptr(wr_ptr_p1);
    end else if (push_a) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? inc_ptr(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push_a) + CW'(push_b) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_a) begin
      q_r[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      q_r[wr_ptr_p1] <= data_b;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue count over depth");

  a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push_b |-> push_a)
    else $error("second result pushed without first");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_a |-> room2)
    else $error("result pushed into full queue");

endmodule

>>> rtl/segment_index_box_parser.sv
// Segment index box parser, one box byte per item.
// A completed result is queued as its last byte is accepted, then shown on out_.
// Throughput: one byte per cycle; a byte can raise two results, which queue in a
// RES_DEPTH-entry result queue; input stalls only while that queue holds more than RES_DEPTH-2.
// Reset (rst_n low, synchronous): parser idle waiting for a box start, queue empty.
module segment_index_box_parser #(
  parameter int unsigned RES_DEPTH = sidx_pkg::RES_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sidx_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sidx_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_SIZE, PH_TYPE, PH_VERFLAGS, PH_REFID, PH_TIMESCALE,
    PH_EARLIEST, PH_OFFSET, PH_RESERVED, PH_COUNT, PH_ENTRY, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fbc_r, fbc_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [31:0] box_size_r, box_size_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [31:0] ref_id_r, ref_id_nxt;
  logic [31:0] tscale_r, tscale_nxt;
  logic [63:0] earliest_r, earliest_nxt;
  logic [63:0] offset_r, offset_nxt;
  logic [15:0] refs_left_r, refs_left_nxt;
  logic [31:0] exp_bytes_r, exp_bytes_nxt;
  logic [31:0] word1_r, word1_nxt;
  logic [31:0] word2_r, word2_nxt;
  logic [15:0] count_r, count_nxt;

  logic        accept, start, room2;
  phase_t      ph;
  logic [3:0]  fbc_inc, field_len;
  logic [63:0] asm_sh;
  logic [31:0] exp_inc, w;
  logic [15:0] rl_dec;
  logic        size_bad;
  logic        push_a, push_b;
  sidx_pkg::out_item_t res_a, res_b;

  assign accept   = in_valid && !in_stall;
  assign in_stall = !room2;
  assign start    = in_data.box_start;

  // phase after a possible restart, and the shifted-in byte
  always_comb begin
    ph        = start ? PH_SIZE : phase_r;
    asm_sh    = {(start ? 56'd0 : asm_r[55:0]), in_data.data_byte};
    fbc_inc   = (start ? 4'd0 : fbc_r) + 4'd1;
    exp_inc   = (start ? 32'd0 : exp_bytes_r) + 32'd1;
    rl_dec    = (start ? 16'd0 : refs_left_r) - 16'd1;
    w         = asm_sh[31:0];
    size_bad  = (exp_inc != box_size_r);
    case (ph)
      PH_EARLIEST, PH_OFFSET: field_len = (version_r == 8'd0) ? 4'd4 : 4'd8;
      PH_RESERVED, PH_COUNT:  field_len = 4'd2;
      default:                field_len = 4'd4;
    endcase
  end

  // field assembly and result generation
  always_comb begin
    phase_nxt     = phase_r;
    fbc_nxt       = fbc_r;
    asm_nxt       = asm_r;
    box_size_nxt  = box_size_r;
    version_nxt   = version_r;
    ref_id_nxt    = ref_id_r;
    tscale_nxt    = tscale_r;
    earliest_nxt  = earliest_r;
    offset_nxt    = offset_r;
    refs_left_nxt = refs_left_r;
    exp_bytes_nxt = exp_bytes_r;
    word1_nxt     = word1_r;
    word2_nxt     = word2_r;
    count_nxt     = count_r;
    push_a        = 1'b0;
    push_b        = 1'b0;
    res_a         = '0;
    res_b         = '0;

    if (accept) begin
      if (start) begin
        phase_nxt     = PH_SIZE;
        fbc_nxt       = '0;
        asm_nxt       = '0;
        exp_bytes_nxt = '0;
        refs_left_nxt = '0;
        count_nxt     = '0;
      end
      if (ph != PH_IDLE && ph != PH_DONE) begin
        asm_nxt       = asm_sh;
        fbc_nxt       = fbc_inc;
        exp_bytes_nxt = exp_inc;
        if (ph == PH_ENTRY) begin
          // 12-byte reference entry: two stored words, third word completes it
          if (fbc_inc == 4'd4) begin
            word1_nxt = w;
          end else if (fbc_inc == 4'd8) begin
            word2_nxt = w;
          end else if (fbc_inc >= 4'd12) begin
            refs_left_nxt         = rl_dec;
            push_a                = 1'b1;
            res_a.kind            = sidx_pkg::KIND_ENTRY;
            res_a.last            = (rl_dec == 16'd0);
            res_a.status          = (rl_dec == 16'd0 && size_bad) ?
                                    sidx_pkg::STATUS_SIZE_MISMATCH : sidx_pkg::STATUS_OK;
            res_a.value_a         = {33'd0, word1_r[30:0]};
            res_a.value_b         = {32'd0, word2_r};
            res_a.reference_count = count_r;
            res_a.reference_type  = word1_r[31];
            res_a.starts_with_sap = w[31];
            res_a.sap_type        = w[30:28];
            res_a.sap_delta_time  = w[27:0];
            fbc_nxt               = '0;
            asm_nxt               = '0;
            if (rl_dec == 16'd0) begin
              phase_nxt = PH_DONE;
            end
          end
        end else if (fbc_inc >= field_len) begin
          // header field complete
          fbc_nxt = '0;
          asm_nxt = '0;
          case (ph)
            PH_SIZE: begin
              box_size_nxt = w;
              phase_nxt    = PH_TYPE;
            end
            PH_TYPE: begin
              if (box_size_r == 32'd1) begin
                push_a       = 1'b1;
                res_a.kind   = sidx_pkg::KIND_HDR_IDS;
                res_a.last   = 1'b1;
                res_a.status = sidx_pkg::STATUS_LARGE_SIZE;
                phase_nxt    = PH_DONE;
              end else begin
                phase_nxt = PH_VERFLAGS;
              end
            end
            PH_VERFLAGS: begin
              version_nxt = w[31:24];
              phase_nxt   = PH_REFID;
            end
            PH_REFID: begin
              ref_id_nxt = w;
              phase_nxt  = PH_TIMESCALE;
            end
            PH_TIMESCALE: begin
              tscale_nxt = w;
              phase_nxt  = PH_EARLIEST;
            end
            PH_EARLIEST: begin
              earliest_nxt = asm_sh;
              phase_nxt    = PH_OFFSET;
            end
            PH_OFFSET: begin
              offset_nxt = asm_sh;
              phase_nxt  = PH_RESERVED;
            end
            PH_RESERVED: begin
              phase_nxt = PH_COUNT;
            end
            PH_COUNT: begin
              refs_left_nxt         = w[15:0];
              count_nxt             = w[15:0];
              push_a                = 1'b1;
              push_b                = 1'b1;
              res_a.kind            = sidx_pkg::KIND_HDR_IDS;
              res_a.value_a         = {32'd0, ref_id_r};
              res_a.value_b         = {32'd0, tscale_r};
              res_a.reference_count = w[15:0];
              res_b.kind            = sidx_pkg::KIND_HDR_TIMES;
              res_b.value_a         = earliest_r;
              res_b.value_b         = offset_r;
              res_b.reference_count = w[15:0];
              if (w[15:0] == 16'd0) begin
                res_b.last   = 1'b1;
                res_b.status = size_bad ? sidx_pkg::STATUS_SIZE_MISMATCH
                                        : sidx_pkg::STATUS_OK;
                phase_nxt    = PH_DONE;
              end else begin
                phase_nxt = PH_ENTRY;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      fbc_r       <= '0;
      asm_r       <= '0;
      box_size_r  <= '0;
      version_r   <= '0;
      ref_id_r    <= '0;
      tscale_r    <= '0;
      earliest_r  <= '0;
      offset_r    <= '0;
      refs_left_r <= '0;
      exp_bytes_r <= '0;
      word1_r     <= '0;
      word2_r     <= '0;
      count_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      fbc_r       <= fbc_nxt;
      asm_r       <= asm_nxt;
      box_size_r  <= box_size_nxt;
      version_r   <= version_nxt;
      ref_id_r    <= ref_id_nxt;
      tscale_r    <= tscale_nxt;
      earliest_r  <= earliest_nxt;
      offset_r    <= offset_nxt;
      refs_left_r <= refs_left_nxt;
      exp_bytes_r <= exp_bytes_nxt;
      word1_r     <= word1_nxt;
      word2_r     <= word2_nxt;
      count_r     <= count_nxt;
    end
  end

  // result queue between parser and output channel
  sidx_res_fifo #(
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .data_a    (res_a),
    .push_b    (push_b),
    .data_b    (res_b),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_pair_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    push_b |-> (res_a.kind == sidx_pkg::KIND_HDR_IDS &&
                res_b.kind == sidx_pkg::KIND_HDR_TIMES))
    else $error("header result pair out of order");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (push_a && !push_b && res_a.last) || (push_b && res_b.last) |=> phase_r == PH_DONE)
    else $error("parser not done after final result");

  a_large_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_a && res_a.status == sidx_pkg::STATUS_LARGE_SIZE) |->
      (res_a.last && res_a.kind == sidx_pkg::KIND_HDR_IDS && !push_b))
    else $error("large size report not a lone final header result");

endmodule

>>> tb/sidx_parse_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the segment index box parser, predicts the
// results of every accepted byte and compares them with what comes out.
module sidx_parse_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sidx_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sidx_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);

  localparam int PRINT_CAP = 40;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIZE, ST_TYPE, ST_VERFLAGS, ST_REFID, ST_TIMESCALE,
    ST_EARLIEST, ST_OFFSET, ST_RESERVED, ST_COUNT, ST_ENTRY, ST_DONE
  } parse_state_t;

  // Parser state as the block should hold it
  parse_state_t phase;
  logic [3:0]   field_bytes;
  logic [63:0]  shift_word;
  logic [31:0]  size_field;
  logic [7:0]   version_field;
  logic [31:0]  ref_id;
  logic [31:0]  ts_value;
  logic [63:0]  earliest_pts;
  logic [63:0]  first_offset;
  logic [15:0]  entries_left;
  logic [15:0]  entries_announced;
  logic [31:0]  bytes_seen;
  logic [31:0]  entry_word1;
  logic [31:0]  entry_word2;

  // Results still owed by the block, oldest first
  sidx_pkg::out_item_t box_results[$];

  initial fail_count = 0;
  initial pending_count = 0;

  task automatic clear_parser();
    phase = ST_IDLE;
    field_bytes = '0;
    shift_word = '0;
    size_field = '0;
    version_field = '0;
    ref_id = '0;
    ts_value = '0;
    earliest_pts = '0;
    first_offset = '0;
    entries_left = '0;
    entries_announced = '0;
    bytes_seen = '0;
    entry_word1 = '0;
    entry_word2 = '0;
  endtask

  function automatic sidx_pkg::out_item_t make_result(logic [1:0] kind, logic last,
                                                      logic [1:0] status,
                                                      logic [63:0] a, logic [63:0] b,
                                                      logic rtype, logic sap,
                                                      logic [2:0] stype,
                                                      logic [27:0] sdelta);
    sidx_pkg::out_item_t r;
    r.kind = kind;
    r.last = last;
    r.status = status;
    r.value_a = a;
    r.value_b = b;
    r.reference_count = entries_announced;
    r.reference_type = rtype;
    r.starts_with_sap = sap;
    r.sap_type = stype;
    r.sap_delta_time = sdelta;
    return r;
  endfunction

  function automatic logic [1:0] size_check();
    return (bytes_seen != size_field) ? sidx_pkg::STATUS_SIZE_MISMATCH
                                      : sidx_pkg::STATUS_OK;
  endfunction

  // Advance the parser by one accepted byte, queue any results it raises
  task automatic predict_box_byte(sidx_pkg::in_item_t item);
    logic [31:0] w;
    logic [3:0]  need;
    logic        fin;
    if (item.box_start) begin
      phase = ST_SIZE;
      field_bytes = '0;
      shift_word = '0;
      bytes_seen = '0;
      entries_left = '0;
      entries_announced = '0;
    end
    if (phase == ST_IDLE || phase == ST_DONE) return;

    shift_word = {shift_word[55:0], item.data_byte};
    field_bytes = field_bytes + 4'd1;
    bytes_seen = bytes_seen + 32'd1;
    w = shift_word[31:0];

    // Reference entries: three words each, one result per entry
    if (phase == ST_ENTRY) begin
      if (field_bytes == 4'd4) begin
        entry_word1 = w;
      end else if (field_bytes == 4'd8) begin
        entry_word2 = w;
      end else if (field_bytes >= 4'd12) begin
        entries_left = entries_left - 16'd1;
        fin = (entries_left == '0);
        box_results.push_back(make_result(sidx_pkg::KIND_ENTRY, fin,
                                          fin ? size_check() : sidx_pkg::STATUS_OK,
                                          {33'd0, entry_word1[30:0]},
                                          {32'd0, entry_word2},
                                          entry_word1[31], w[31], w[30:28],
                                          w[27:0]));
        field_bytes = '0;
        shift_word = '0;
        if (fin) phase = ST_DONE;
      end
      return;
    end

    case (phase)
      ST_EARLIEST, ST_OFFSET: need = (version_field == '0) ? 4'd4 : 4'd8;
      ST_RESERVED, ST_COUNT:  need = 4'd2;
      default:                need = 4'd4;
    endcase
    if (field_bytes < need) return;

    case (phase)
      ST_SIZE:      size_field = w;
      ST_TYPE: begin
        if (size_field == 32'd1) begin
          box_results.push_back(make_result(sidx_pkg::KIND_HDR_IDS, 1'b1,
                                            sidx_pkg::STATUS_LARGE_SIZE,
                                            '0, '0, 1'b0, 1'b0, '0, '0));
          phase = ST_DONE;
          field_bytes = '0;
          shift_word = '0;
          return;
        end
      end
      ST_VERFLAGS:  version_field = w[31:24];
      ST_REFID:     ref_id = w;
      ST_TIMESCALE: ts_value = w;
      ST_EARLIEST:  earliest_pts = shift_word;
      ST_OFFSET:    first_offset = shift_word;
      ST_RESERVED:  ;
      default: begin
        // reference count completes the header: two results
        entries_left = w[15:0];
        entries_announced = w[15:0];
        box_results.push_back(make_result(sidx_pkg::KIND_HDR_IDS, 1'b0,
                                          sidx_pkg::STATUS_OK,
                                          {32'd0, ref_id}, {32'd0, ts_value},
                                          1'b0, 1'b0, '0, '0));
        fin = (entries_left == '0);
        box_results.push_back(make_result(sidx_pkg::KIND_HDR_TIMES, fin,
                                          fin ? size_check() : sidx_pkg::STATUS_OK,
                                          earliest_pts, first_offset,
                                          1'b0, 1'b0, '0, '0));
        phase = fin ? ST_DONE : ST_ENTRY;
        field_bytes = '0;
        shift_word = '0;
        return;
      end
    endcase
    phase = parse_state_t'(phase + 4'd1);
    field_bytes = '0;
    shift_word = '0;
  endtask

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic compare_result(sidx_pkg::out_item_t got, sidx_pkg::out_item_t want);
    if (got.kind != want.kind)
      note_mismatch("kind", 64'(got.kind), 64'(want.kind));
    if (got.last != want.last)
      note_mismatch("last", 64'(got.last), 64'(want.last));
    if (got.status != want.status)
      note_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.value_a != want.value_a) note_mismatch("value_a", got.value_a, want.value_a);
    if (got.value_b != want.value_b) note_mismatch("value_b", got.value_b, want.value_b);
    if (got.reference_count != want.reference_count)
      note_mismatch("reference_count", 64'(got.reference_count),
                    64'(want.reference_count));
    if (got.reference_type != want.reference_type)
      note_mismatch("reference_type", 64'(got.reference_type),
                    64'(want.reference_type));
    if (got.starts_with_sap != want.starts_with_sap)
      note_mismatch("starts_with_sap", 64'(got.starts_with_sap),
                    64'(want.starts_with_sap));
    if (got.sap_type != want.sap_type)
      note_mismatch("sap_type", 64'(got.sap_type), 64'(want.sap_type));
    if (got.sap_delta_time != want.sap_delta_time)
      note_mismatch("sap_delta_time", 64'(got.sap_delta_time),
                    64'(want.sap_delta_time));
  endtask

  // Results first: a byte's results come out no earlier than the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      box_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (box_results.size() == 0)
          note_mismatch("result with none owed, kind", 64'(out_data.kind), '0);
        else
          compare_result(out_data, box_results.pop_front());
      end
      if (in_valid && !in_stall) predict_box_byte(in_data);
    end
    pending_count = box_results.size();
  end

endmodule

>>> tb/segment_index_box_parser_test.sv
`timescale 1ns / 1ps

module segment_index_box_parser_test;

  localparam int BYTE_TARGET = 1200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sidx_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  sidx_pkg::out_item_t out_data;

  int fail_count;
  int pending_count;
  int cycle_count;
  int box_bytes_sent;

  // per-box idle switches, so some boxes run with no gaps at all
  logic idle_in;
  logic idle_out;

  logic [7:0] box_bytes[$];

  segment_index_box_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sidx_parse_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run guard
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: when idle_out is set, may stall before each item, then take it
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = idle_out ? $urandom_range(0, 4) : 0;
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Present one byte, after a random gap when idle_in is set; returns at the accepting edge
  task automatic send_byte(logic [7:0] b, logic start);
    int gap;
    gap = idle_in ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, start};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_queued(logic first_start);
    foreach (box_bytes[i]) send_byte(box_bytes[i], first_start && (i == 0));
    box_bytes.delete();
  endtask

  // Hold the input off until every owed result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic void push_be(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) box_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Build one segment index box with random content into box_bytes
  function automatic void build_box();
    logic [7:0]  ver;
    logic [15:0] count;
    logic [31:0] size_word;
    int          entries;
    int          body_len;
    int          r;
    int          cut;
    ver = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
    r = $urandom_range(0, 99);
    if (r < 20) count = '0;
    else if (r < 92) count = 16'($urandom_range(1, 4));
    else count = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
    // huge counts get 0 to 2 entries, so the box ends short of its count
    entries = (count > 16'd4) ? $urandom_range(0, 2) : int'(count);
    body_len = 32 + (ver != '0 ? 8 : 0) + 12 * int'(count);

    if ($urandom_range(0, 3) != 0) size_word = 32'(body_len);
    else size_word = 32'(pick_value());
    push_be(64'(size_word), 4);
    push_be($urandom_range(0, 4) != 0 ? 64'h73696478 : {32'd0, $urandom}, 4);
    push_be(64'({ver, 24'($urandom)}), 4);
    push_be(pick_value(), 4);
    push_be(pick_value(), 4);
    push_be(pick_value(), ver != '0 ? 8 : 4);
    push_be(pick_value(), ver != '0 ? 8 : 4);
    push_be(64'(16'($urandom)), 2);
    push_be(64'(count), 2);
    for (int e = 0; e < entries; e++) begin
      push_be(pick_value(), 4);
      push_be(pick_value(), 4);
      push_be(pick_value(), 4);
    end

    // truncated box: next box_start drops it
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, box_bytes.size() - 1);
      while (box_bytes.size() > cut) void'(box_bytes.pop_back());
    end
  endfunction

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_in = 1'b1;
    idle_out = 1'b1;
    box_bytes_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: bytes before any box are ignored
    push_be(64'hFF00, 2);
    send_queued(1'b0);
    // partial box with all-ones bytes, dropped by the next box start
    push_be(64'hFFFFFF, 3);
    send_queued(1'b1);
    // large size box, then trailing bytes that must be ignored
    push_be(64'd1, 4);
    push_be(64'h73696478, 4);
    send_queued(1'b1);
    push_be(64'hAB55, 2);
    send_queued(1'b0);
    wait_drained();

    // Random boxes with noise, large sizes and trailing bytes mixed in
    while (box_bytes_sent < BYTE_TARGET) begin
      idle_in = ($urandom_range(0, 3) != 0);
      idle_out = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        push_be(64'd1, 4);
        push_be({$urandom, $urandom}, int'($urandom_range(4, 8)));
        send_queued(1'b1);
      end else if (r < 14) begin
        for (int i = $urandom_range(1, 6); i > 0; i--) box_bytes.push_back(8'($urandom));
        send_queued(1'b0);
      end else begin
        build_box();
        box_bytes_sent += box_bytes.size();
        send_queued(1'b1);
        if ($urandom_range(0, 4) == 0) begin
          for (int i = $urandom_range(1, 3); i > 0; i--) box_bytes.push_back(8'($urandom));
          send_queued(1'b0);
        end
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    // Drain and let any stray result show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
